FILE: rtl/core/bsf_pkg.sv
// Package for the box sum filter: sizes, field widths and the per-item control word.
package bsf_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int MAX_WIN    = 16;
    localparam int PIXEL_BITS = 16;

    localparam int COL_BITS  = 10;
    localparam int ROW_BITS  = 12;
    localparam int IROW_BITS = 13;
    localparam int WIN_BITS  = 4;
    localparam int CSUM_BITS = 21;
    localparam int BOX_BITS  = 24;
    localparam int FW_BITS   = 11;
    localparam int FH_BITS   = 13;
    localparam int WW_BITS   = 5;
    localparam int CFG_BITS  = 13;
    localparam int IDX_BITS  = 2;

    localparam logic [IDX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [IDX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [IDX_BITS-1:0] REG_WIN_WIDTH    = 2'd2;
    localparam logic [IDX_BITS-1:0] REG_WIN_HEIGHT   = 2'd3;

    typedef struct packed {
        logic signed [PIXEL_BITS-1:0] pix;
        logic                         is_pixel;
        logic                         first_row;
        logic                         sub_row;
        logic                         sub_rec;
        logic                         col0;
        logic                         emit;
        logic                         valid;
        logic [COL_BITS-1:0]          col;
        logic [WIN_BITS-1:0]          wr_row;
        logic [WIN_BITS-1:0]          rd_row;
        logic [WIN_BITS-1:0]          rec_wr;
        logic [WIN_BITS-1:0]          rec_rd;
        logic [COL_BITS-1:0]          ocol;
        logic [ROW_BITS-1:0]          orow;
        logic                         last;
    } bsf_item_t;

endpackage

FILE: rtl/core/bsf_stream_if.sv
// Valid/ready stream interfaces for the input pixels and the window sums.
interface bsf_in_if;
    import bsf_pkg::*;
    logic                         valid;
    logic                         ready;
    logic signed [PIXEL_BITS-1:0] pixel;
    logic                         drain;
    modport source (output valid, output pixel, output drain, input ready);
    modport sink   (input valid, input pixel, input drain, output ready);
endinterface

interface bsf_out_if;
    import bsf_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [BOX_BITS-1:0] box_sum;
    logic [COL_BITS-1:0]        out_col;
    logic [ROW_BITS-1:0]        out_row;
    logic                       frame_end;
    modport source (output valid, output box_sum, output out_col, output out_row,
                    output frame_end, input ready);
    modport sink   (input valid, input box_sum, input out_col, input out_row,
                    input frame_end, output ready);
endinterface

FILE: rtl/core/bsf_ctrl.sv
// Raster counters, configuration registers and per-item control decode.
module bsf_ctrl
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bsf_pkg::IDX_BITS-1:0]   cfg_index,
    input  logic [bsf_pkg::CFG_BITS-1:0]   cfg_data,
    input  logic                           take,
    input  logic signed [bsf_pkg::PIXEL_BITS-1:0] pixel,
    input  logic                           drain,
    output logic                           go,
    output bsf_pkg::bsf_item_t             item
);
    import bsf_pkg::*;

    logic [FW_BITS-1:0]   fw_reg;
    logic [FH_BITS-1:0]   fh_reg;
    logic [WW_BITS-1:0]   ww_reg;
    logic [WW_BITS-1:0]   wh_reg;
    logic [COL_BITS-1:0]  icol_reg, icol_next;
    logic [IROW_BITS-1:0] irow_reg, irow_next;
    logic [COL_BITS-1:0]  ocol_reg, ocol_next;
    logic [ROW_BITS-1:0]  orow_reg, orow_next;
    logic                 tail_reg, tail_next;

    logic [FW_BITS-1:0]   w;
    logic [FH_BITS-1:0]   h;
    logic [WW_BITS-1:0]   ww, wh;
    logic [WW_BITS-1:0]   dx, dy;
    logic [24:0]          delay, pos;
    logic [COL_BITS-1:0]  oc;
    logic [ROW_BITS-1:0]  orr;
    logic                 o_last, do_emit, col_end, row_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= FW_BITS'(1024);
            fh_reg <= FH_BITS'(768);
            ww_reg <= WW_BITS'(3);
            wh_reg <= WW_BITS'(3);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  fw_reg <= cfg_data[FW_BITS-1:0];
                REG_FRAME_HEIGHT: fh_reg <= cfg_data[FH_BITS-1:0];
                REG_WIN_WIDTH:    ww_reg <= cfg_data[WW_BITS-1:0];
                REG_WIN_HEIGHT:   wh_reg <= cfg_data[WW_BITS-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        w  = (fw_reg == '0) ? FW_BITS'(1) :
             (fw_reg > FW_BITS'(MAX_WIDTH)) ? FW_BITS'(MAX_WIDTH) : fw_reg;
        h  = (fh_reg == '0) ? FH_BITS'(1) :
             (fh_reg > FH_BITS'(MAX_HEIGHT)) ? FH_BITS'(MAX_HEIGHT) : fh_reg;
        ww = (ww_reg == '0) ? WW_BITS'(1) :
             (ww_reg > WW_BITS'(MAX_WIN)) ? WW_BITS'(MAX_WIN) : ww_reg;
        wh = (wh_reg == '0) ? WW_BITS'(1) :
             (wh_reg > WW_BITS'(MAX_WIN)) ? WW_BITS'(MAX_WIN) : wh_reg;
        dx = ww - WW_BITS'(1) - (ww >> 1);
        dy = wh - WW_BITS'(1) - (wh >> 1);
        delay = 25'(dy) * 25'(w) + 25'(dx);
        pos   = 25'(irow_reg) * 25'(w) + 25'(icol_reg);

        // a new pixel restarts a frame whose tail was never drained
        oc  = (!drain && tail_reg) ? '0 : ocol_reg;
        orr = (!drain && tail_reg) ? '0 : orow_reg;
        col_end = ({1'b0, oc} + 11'd1) >= w;
        row_end = ({2'b0, orr} + 14'd1) >= {1'b0, h};
        o_last  = col_end && row_end;

        do_emit = drain ? tail_reg : (pos >= delay);
        go      = drain ? tail_reg : 1'b1;

        item.pix       = pixel;
        item.is_pixel  = !drain;
        item.first_row = (irow_reg == '0);
        item.sub_row   = {3'b0, irow_reg} >= 16'(wh);
        item.sub_rec   = {1'b0, icol_reg} >= 11'(ww);
        item.col0      = (icol_reg == '0);
        item.emit      = do_emit;
        item.valid     = (({1'b0, icol_reg} + 11'd1) >= 11'(ww))
                      && (({1'b0, irow_reg} + 14'd1) >= 14'(wh))
                      && !(!ww[0] && (({1'b0, icol_reg} + 11'd1) == w));
        item.col       = icol_reg;
        item.wr_row    = irow_reg[WIN_BITS-1:0];
        item.rd_row    = irow_reg[WIN_BITS-1:0] - wh[WIN_BITS-1:0];
        item.rec_wr    = icol_reg[WIN_BITS-1:0];
        item.rec_rd    = icol_reg[WIN_BITS-1:0] - ww[WIN_BITS-1:0];
        item.ocol      = oc;
        item.orow      = orr;
        item.last      = o_last;

        icol_next = icol_reg;
        irow_next = irow_reg;
        ocol_next = oc;
        orow_next = orr;
        tail_next = drain ? tail_reg : 1'b0;

        if (do_emit)
        begin
            if (col_end)
            begin
                ocol_next = '0;
                orow_next = row_end ? '0 : orr + ROW_BITS'(1);
            end
            else
            begin
                ocol_next = oc + COL_BITS'(1);
            end
            if (drain && o_last)
                tail_next = 1'b0;
        end

        if (!drain)
        begin
            if (({1'b0, icol_reg} + 11'd1) >= w)
            begin
                icol_next = '0;
                if (({1'b0, irow_reg} + 14'd1) >= {1'b0, h})
                begin
                    irow_next = '0;
                    tail_next = (delay != '0);
                end
                else
                begin
                    irow_next = irow_reg + IROW_BITS'(1);
                end
            end
            else
            begin
                icol_next = icol_reg + COL_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            icol_reg <= '0;
            irow_reg <= '0;
            ocol_reg <= '0;
            orow_reg <= '0;
            tail_reg <= 1'b0;
        end
        else if (take)
        begin
            icol_reg <= icol_next;
            irow_reg <= irow_next;
            ocol_reg <= ocol_next;
            orow_reg <= orow_next;
            tail_reg <= tail_next;
        end
    end

endmodule

FILE: rtl/core/box_sum_filter_2d.sv
// Top level of the streaming 2-D box sum filter: line stores, running sums, output register.
// Path: an accepted item is held in the stage 1 register, then in the output register.
// Throughput: one item per cycle unless the output stalls; column-sum and line stores are
// read at accept and written as the item leaves stage 1, with same-entry forwarding.
// Reset: counters, running sum, tail flag and valids clear; config regs take their
// reset sizes; line and column stores are left undefined (no clearing pass).
module box_sum_filter_2d
(
    input  logic                         clk,
    input  logic                         rst_n,
    bsf_in_if.sink                       in_ch,
    bsf_out_if.source                    out_ch,
    input  logic                         cfg_we,
    input  logic [bsf_pkg::IDX_BITS-1:0] cfg_index,
    input  logic [bsf_pkg::CFG_BITS-1:0] cfg_data
);
    import bsf_pkg::*;

    // column sums, one per column
    logic signed [CSUM_BITS-1:0]  col_mem [0:MAX_WIDTH-1];
    // last MAX_WIN lines of raw pixels, row-major {row mod MAX_WIN, col}
    logic signed [PIXEL_BITS-1:0] row_mem [0:MAX_WIN*MAX_WIDTH-1];
    // column sums of the current line, last MAX_WIN columns
    logic signed [CSUM_BITS-1:0]  rec_reg [0:MAX_WIN-1];

    logic                         in_take, go, s1_adv, s1_wr;
    bsf_item_t                    item, s1_reg;
    logic                         s1_valid_reg;

    logic signed [CSUM_BITS-1:0]  col_q_reg, fwd_col_val_reg;
    logic signed [PIXEL_BITS-1:0] row_q_reg, fwd_row_val_reg;
    logic                         fwd_col_reg, fwd_row_reg;

    logic signed [CSUM_BITS-1:0]  col_v, cs;
    logic signed [PIXEL_BITS-1:0] row_v;
    logic signed [BOX_BITS-1:0]   rs_reg, rs_next;

    logic                         ov_reg;
    logic signed [BOX_BITS-1:0]   obox_reg;
    logic [COL_BITS-1:0]          ocol_reg;
    logic [ROW_BITS-1:0]          orow_reg;
    logic                         olast_reg;

    // stage 1 moves on when the output register is free or being emptied
    assign s1_adv   = s1_valid_reg && (!ov_reg || out_ch.ready);
    assign s1_wr    = s1_adv && s1_reg.is_pixel;
    assign in_ch.ready = !s1_valid_reg || s1_adv;
    assign in_take  = in_ch.valid && in_ch.ready;

    bsf_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .take      (in_take),
        .pixel     (in_ch.pixel),
        .drain     (in_ch.drain),
        .go        (go),
        .item      (item)
    );

    // stage 1 datapath
    always_comb
    begin
        col_v = fwd_col_reg ? fwd_col_val_reg : col_q_reg;
        row_v = fwd_row_reg ? fwd_row_val_reg : row_q_reg;
        if (s1_reg.first_row)
            cs = CSUM_BITS'(s1_reg.pix);
        else
            cs = col_v + CSUM_BITS'(s1_reg.pix)
               - (s1_reg.sub_row ? CSUM_BITS'(row_v) : CSUM_BITS'(0));
        rs_next = (s1_reg.col0 ? BOX_BITS'(0) : rs_reg) + BOX_BITS'(cs)
                - (s1_reg.sub_rec ? BOX_BITS'(rec_reg[s1_reg.rec_rd]) : BOX_BITS'(0));
    end

    // stores: read at accept, write when the item leaves stage 1
    always_ff @(posedge clk)
    begin
        if (s1_wr)
        begin
            col_mem[s1_reg.col] <= cs;
            row_mem[{s1_reg.wr_row, s1_reg.col}] <= s1_reg.pix;
            rec_reg[s1_reg.rec_wr] <= cs;
        end
        if (in_take)
        begin
            col_q_reg <= col_mem[item.col];
            row_q_reg <= row_mem[{item.rd_row, item.col}];
            // same entry written this cycle: read returns old data, so bypass
            fwd_col_val_reg <= cs;
            fwd_row_val_reg <= s1_reg.pix;
            s1_reg <= item;
        end
        if (s1_adv && s1_reg.emit)
        begin
            obox_reg  <= (s1_reg.is_pixel && s1_reg.valid) ? rs_next : BOX_BITS'(0);
            ocol_reg  <= s1_reg.ocol;
            orow_reg  <= s1_reg.orow;
            olast_reg <= s1_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_col_reg  <= 1'b0;
            fwd_row_reg  <= 1'b0;
            rs_reg       <= '0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                s1_valid_reg <= go;
                fwd_col_reg  <= s1_wr && (s1_reg.col == item.col);
                fwd_row_reg  <= s1_wr && (s1_reg.col == item.col)
                             && (s1_reg.wr_row == item.rd_row);
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_wr)
                rs_reg <= rs_next;
            if (s1_adv && s1_reg.emit)
                ov_reg <= 1'b1;
            else if (out_ch.ready)
                ov_reg <= 1'b0;
        end
    end

    assign out_ch.valid     = ov_reg;
    assign out_ch.box_sum   = obox_reg;
    assign out_ch.out_col   = ocol_reg;
    assign out_ch.out_row   = orow_reg;
    assign out_ch.frame_end = olast_reg;

endmodule
